[src/csb_pkg.sv]
// shared types and constants of the cursor sequence buffer
package csb_pkg;

    // default storage shape
    localparam int DEPTH_DEF      = 32;
    localparam int WORD_WIDTH_DEF = 32;

    // fixed port field widths
    localparam int MODE_W  = 2;
    localparam int ENTRY_W = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 6;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_START   = 2'd0,
        MODE_ADVANCE = 2'd1,
        MODE_INSERT  = 2'd2,
        MODE_READ    = 2'd3
    } t_mode;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_RESULT
    } t_state;

    // result status from the sequencer to the output register
    typedef struct packed {
        logic               load;
        logic               has;
        logic               refused;
        logic [COUNT_W-1:0] count;
    } t_res;

endpackage

[src/csb_ram.sv]
// generic simple dual-port ram with registered read
module csb_ram #(
    parameter int WIDTH = csb_pkg::WORD_WIDTH_DEF,
    parameter int DEPTH = csb_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/csb_seq.sv]
// sequencer: cursor and count registers, shift loop over the item ram
module csb_seq #(
    parameter int DEPTH      = csb_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = csb_pkg::WORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_busy,
    input  csb_pkg::t_mode           i_mode,
    input  logic [WORD_WIDTH-1:0]    i_word,
    input  logic                     i_out_free,
    output csb_pkg::t_res            o_res,
    output logic [WORD_WIDTH-1:0]    o_value,
    output logic                     o_wr_en,
    output logic [$clog2(DEPTH)-1:0] o_wr_addr,
    output logic [WORD_WIDTH-1:0]    o_wr_data,
    output logic                     o_rd_en,
    output logic [$clog2(DEPTH)-1:0] o_rd_addr,
    input  logic [WORD_WIDTH-1:0]    i_rd_data
);

    localparam int AddrW  = $clog2(DEPTH);
    localparam int CntW   = $clog2(DEPTH + 1);
    localparam int CountW = csb_pkg::COUNT_W;

    csb_pkg::t_state       r_state, n_state;
    logic [CntW-1:0]       r_cursor, n_cursor;
    logic [CntW-1:0]       r_count, n_count;
    logic [AddrW-1:0]      r_idx, n_idx;
    logic [WORD_WIDTH-1:0] r_word, n_word;
    logic                  r_use_word, n_use_word;
    logic                  r_refused, n_refused;

    logic                  w_accept;
    logic                  w_cur_ok;
    logic                  w_full;
    logic [AddrW-1:0]      w_idx_dec;

    assign w_accept  = i_valid && (r_state == csb_pkg::S_IDLE);
    assign w_cur_ok  = r_cursor < r_count;
    assign w_full    = r_count == CntW'(DEPTH);
    assign w_idx_dec = r_idx - AddrW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            csb_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_mode == csb_pkg::MODE_INSERT && !w_full) begin
                        n_state = (r_count > r_cursor) ? csb_pkg::S_SHIFT_RD
                                                       : csb_pkg::S_PLACE;
                    end else begin
                        n_state = csb_pkg::S_RESULT;
                    end
                end
            end
            csb_pkg::S_SHIFT_RD: begin
                n_state = csb_pkg::S_SHIFT_WR;
            end
            csb_pkg::S_SHIFT_WR: begin
                n_state = (CntW'(w_idx_dec) > r_cursor) ? csb_pkg::S_SHIFT_RD
                                                        : csb_pkg::S_PLACE;
            end
            csb_pkg::S_PLACE: begin
                n_state = csb_pkg::S_RESULT;
            end
            csb_pkg::S_RESULT: begin
                if (i_out_free) begin
                    n_state = csb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = csb_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_cursor   = r_cursor;
        n_count    = r_count;
        n_idx      = r_idx;
        n_word     = r_word;
        n_use_word = r_use_word;
        n_refused  = r_refused;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_idx;
        o_wr_data  = i_rd_data;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_idx;
        o_res      = '0;
        unique case (r_state)
            csb_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_word     = i_word;
                    n_use_word = 1'b0;
                    n_refused  = 1'b0;
                    case (i_mode)
                        csb_pkg::MODE_START: begin
                            n_cursor = '0;
                        end
                        csb_pkg::MODE_ADVANCE: begin
                            if (w_cur_ok) begin
                                n_cursor = r_cursor + CntW'(1);
                            end else begin
                                n_refused = 1'b1;
                            end
                        end
                        csb_pkg::MODE_INSERT: begin
                            if (w_full) begin
                                n_refused = 1'b1;
                            end else begin
                                n_use_word = 1'b1;
                                n_idx      = r_count[AddrW-1:0];
                            end
                        end
                        default: begin
                            n_refused = !w_cur_ok;
                        end
                    endcase
                    // fetch the item under the new cursor for the result
                    o_rd_en   = 1'b1;
                    o_rd_addr = n_cursor[AddrW-1:0];
                end
            end
            csb_pkg::S_SHIFT_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = w_idx_dec;
            end
            csb_pkg::S_SHIFT_WR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx;
                o_wr_data = i_rd_data;
                n_idx     = w_idx_dec;
            end
            csb_pkg::S_PLACE: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_cursor[AddrW-1:0];
                o_wr_data = r_word;
                n_count   = r_count + CntW'(1);
            end
            csb_pkg::S_RESULT: begin
                o_res.load    = i_out_free;
                o_res.has     = w_cur_ok;
                o_res.refused = r_refused;
                o_res.count   = CountW'(r_count);
            end
            default: begin
                n_refused = r_refused;
            end
        endcase
    end

    // value reported under the cursor
    always_comb begin
        if (!w_cur_ok) begin
            o_value = '0;
        end else if (r_use_word) begin
            o_value = r_word;
        end else begin
            o_value = i_rd_data;
        end
    end

    assign o_busy = (r_state != csb_pkg::S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= csb_pkg::S_IDLE;
            r_cursor <= '0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_count  <= n_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_word     <= n_word;
        r_use_word <= n_use_word;
        r_refused  <= n_refused;
    end

    // cursor never runs past the stored items
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("cursor beyond item count");

    // count stays within the store
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("item count beyond depth");

    // shift loop only runs above the cursor
    a_shift_above_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csb_pkg::S_SHIFT_RD || r_state == csb_pkg::S_SHIFT_WR)
        |-> (CntW'(r_idx) > r_cursor))
        else $error("shift index at or below cursor");

    // an accepted insert that fits moves the count up by one at placement
    a_place_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csb_pkg::S_PLACE) |=> (r_count == $past(r_count) + CntW'(1)))
        else $error("placement did not grow count");

endmodule

[src/cursor_sequence_buffer_unit.sv]
// top level of the cursor sequence buffer: ports, word sizing, output register
//
// An ordered store of up to DEPTH words with a cursor. Each request carries a
// mode (start, advance, insert before cursor, read current) and a word used
// by insert. Every request yields one result: the item under the cursor after
// the operation (zero if none), whether an item is current, the item count,
// and a refused flag when the operation was illegal and nothing changed.
// Requests come in on i_valid/o_stall, results leave on o_valid/i_stall; a
// transfer happens on a clock edge with valid high and stall low.
// Start, advance, read and a refused insert go from accept straight to the
// result state and then into the output register. An insert moves each item
// from the cursor to the end up one slot through the item ram, with a read and
// then a write back per item, then writes the new word. One request is in
// work at a time; o_stall stays high until its result enters the output
// register, which can hold a finished result while the next request is taken.
// A stalled receiver keeps the result steady and holds back the sequencer.
// Synchronous reset empties the store and clears cursor and count; the ram
// itself is not cleared, as only slots below the count are reported.
module cursor_sequence_buffer_unit #(
    parameter int DEPTH      = csb_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = csb_pkg::WORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [csb_pkg::MODE_W-1:0]  i_mode,
    input  logic [csb_pkg::ENTRY_W-1:0] i_entry_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [csb_pkg::VALUE_W-1:0] o_current_value,
    output logic                        o_has_item,
    output logic [csb_pkg::COUNT_W-1:0] o_item_count,
    output logic                        o_refused
);

    localparam int AddrW = $clog2(DEPTH);

    csb_pkg::t_res         w_res;
    logic [WORD_WIDTH-1:0] w_value;
    logic [WORD_WIDTH-1:0] w_word;
    logic [63:0]           w_entry_wide;
    logic [63:0]           w_value_wide;
    logic                  w_out_free;
    logic                  w_busy;

    logic                  w_wr_en;
    logic [AddrW-1:0]      w_wr_addr;
    logic [WORD_WIDTH-1:0] w_wr_data;
    logic                  w_rd_en;
    logic [AddrW-1:0]      w_rd_addr;
    logic [WORD_WIDTH-1:0] w_rd_data;

    logic                        r_out_valid;
    logic [csb_pkg::VALUE_W-1:0] r_cur_value;
    logic                        r_has_item;
    logic [csb_pkg::COUNT_W-1:0] r_item_count;
    logic                        r_refused;

    // keep the low word bits of the request
    assign w_entry_wide = 64'(i_entry_value);
    assign w_word       = w_entry_wide[WORD_WIDTH-1:0];

    // stored word back to the result field width
    assign w_value_wide = 64'(w_value);

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = w_busy;

    csb_seq #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_busy     (w_busy),
        .i_mode     (csb_pkg::t_mode'(i_mode)),
        .i_word     (w_word),
        .i_out_free (w_out_free),
        .o_res      (w_res),
        .o_value    (w_value),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data)
    );

    csb_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_item_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_res.load) begin
            r_cur_value  <= w_value_wide[csb_pkg::VALUE_W-1:0];
            r_has_item   <= w_res.has;
            r_item_count <= w_res.count;
            r_refused    <= w_res.refused;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_current_value = r_cur_value;
    assign o_has_item      = r_has_item;
    assign o_item_count    = r_item_count;
    assign o_refused       = r_refused;

    // a result is loaded only into a free output register
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.load |-> (!r_out_valid || !i_stall))
        else $error("result loaded over a pending result");

    // no current item means a zero value
    a_empty_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_has_item) |-> (r_cur_value == '0))
        else $error("value reported without a current item");

    // a loaded result arrives as valid on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.load |=> r_out_valid)
        else $error("loaded result not shown");

endmodule

[verif/cursor_sequence_buffer_checker.sv]
// request/result monitor for the cursor sequence buffer: prediction and field compare
module cursor_sequence_buffer_checker #(
    parameter int DEPTH      = csb_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = csb_pkg::WORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_stall,
    input  logic [csb_pkg::MODE_W-1:0]  i_req_mode,
    input  logic [csb_pkg::ENTRY_W-1:0] i_req_entry,
    input  logic                        i_res_valid,
    input  logic                        i_res_stall,
    input  logic [csb_pkg::VALUE_W-1:0] i_res_value,
    input  logic                        i_res_has_item,
    input  logic [csb_pkg::COUNT_W-1:0] i_res_count,
    input  logic                        i_res_refused,
    output int                          o_mismatch_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // what one result shows about the buffer after its request
    typedef struct packed {
        logic [csb_pkg::VALUE_W-1:0] value;
        logic                        has;
        logic [csb_pkg::COUNT_W-1:0] count;
        logic                        refused;
    } t_cursor_view;

    // shadow copy of the buffer contents, fill level and cursor
    logic [WORD_WIDTH-1:0] shadow_items [DEPTH];
    int unsigned           shadow_count;
    int unsigned           shadow_cursor;
    t_cursor_view          pending_views [$];
    int                    mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // apply one request to the shadow buffer and return the view it leaves
    function automatic t_cursor_view predict_cursor_view(
        input csb_pkg::t_mode              op,
        input logic [csb_pkg::ENTRY_W-1:0] word
    );
        t_cursor_view view;
        int unsigned  slot;
        view = '0;
        case (op)
            csb_pkg::MODE_START: begin
                shadow_cursor = 0;
            end
            csb_pkg::MODE_ADVANCE: begin
                if (shadow_cursor < shadow_count) begin
                    shadow_cursor++;
                end else begin
                    view.refused = 1'b1;
                end
            end
            csb_pkg::MODE_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    view.refused = 1'b1;
                end else begin
                    // open a gap at the cursor, the new word becomes current
                    for (slot = shadow_count; slot > shadow_cursor; slot--) begin
                        shadow_items[slot] = shadow_items[slot-1];
                    end
                    shadow_items[shadow_cursor] = WORD_WIDTH'(word);
                    shadow_count++;
                end
            end
            csb_pkg::MODE_READ: begin
                if (shadow_cursor >= shadow_count) begin
                    view.refused = 1'b1;
                end
            end
        endcase
        view.has   = (shadow_cursor < shadow_count);
        view.value = view.has ? csb_pkg::VALUE_W'(shadow_items[shadow_cursor]) : '0;
        view.count = csb_pkg::COUNT_W'(shadow_count);
        return view;
    endfunction

    // results are checked before new requests are predicted in the same cycle
    always @(posedge i_clk) begin
        t_cursor_view want;
        if (!i_rst_n) begin
            shadow_count  = 0;
            shadow_cursor = 0;
            pending_views.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (pending_views.size() == 0) begin
                    report_mismatch($sformatf("result with no request outstanding: %08h %0d",
                                              i_res_value, i_res_count));
                end else begin
                    want = pending_views.pop_front();
                    if (i_res_value !== want.value) begin
                        report_mismatch($sformatf("current_value %08h, predicted %08h",
                                                  i_res_value, want.value));
                    end
                    if (i_res_has_item !== want.has) begin
                        report_mismatch($sformatf("has_item %b, predicted %b",
                                                  i_res_has_item, want.has));
                    end
                    if (i_res_count !== want.count) begin
                        report_mismatch($sformatf("item_count %0d, predicted %0d",
                                                  i_res_count, want.count));
                    end
                    if (i_res_refused !== want.refused) begin
                        report_mismatch($sformatf("refused %b, predicted %b",
                                                  i_res_refused, want.refused));
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                pending_views.push_back(
                    predict_cursor_view(csb_pkg::t_mode'(i_req_mode), i_req_entry));
            end
        end
        o_pending        = pending_views.size();
        o_mismatch_count = mismatches;
    end

endmodule

[verif/cursor_sequence_buffer_unit_tb.sv]
// testbench top for the cursor sequence buffer: clock, reset, request traffic, verdict
module cursor_sequence_buffer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_ITEMS    = 1630;
    localparam int TAIL_ITEMS      = 250;
    localparam int HOLD_OFF_CYCLES = 300;
    // covers the longest insert, plus stalls and the one long hold-off
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 80;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [csb_pkg::MODE_W-1:0]  i_mode;
    logic [csb_pkg::ENTRY_W-1:0] i_entry_value;
    logic                        o_valid;
    logic                        i_stall;
    logic [csb_pkg::VALUE_W-1:0] o_current_value;
    logic                        o_has_item;
    logic [csb_pkg::COUNT_W-1:0] o_item_count;
    logic                        o_refused;

    int mismatch_count;
    int pending_results;
    bit idle_en;
    int hold_off_asked;

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    cursor_sequence_buffer_unit #(
        .DEPTH      (csb_pkg::DEPTH_DEF),
        .WORD_WIDTH (csb_pkg::WORD_WIDTH_DEF)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_entry_value   (i_entry_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_current_value (o_current_value),
        .o_has_item      (o_has_item),
        .o_item_count    (o_item_count),
        .o_refused       (o_refused)
    );

    cursor_sequence_buffer_checker #(
        .DEPTH      (csb_pkg::DEPTH_DEF),
        .WORD_WIDTH (csb_pkg::WORD_WIDTH_DEF)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_req_mode       (i_mode),
        .i_req_entry      (i_entry_value),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_res_value      (o_current_value),
        .i_res_has_item   (o_has_item),
        .i_res_count      (o_item_count),
        .i_res_refused    (o_refused),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_results)
    );

    // offer one request from a falling edge, hold it until taken
    task automatic send_request(input csb_pkg::t_mode op,
                                input logic [csb_pkg::ENTRY_W-1:0] word);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= op;
        i_entry_value <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // result side: stall bursts, and one long hold-off on request
    initial begin : result_taker
        int hold_off_done;
        hold_off_done = 0;
        i_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_asked != hold_off_done) begin
                hold_off_done++;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // end the run if neither channel moves for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("[%0t] watchdog: no request or result moved in %0d cycles",
                 $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int                          item;
        int                          pick;
        csb_pkg::t_mode              op;
        logic [csb_pkg::ENTRY_W-1:0] word;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_mode         <= csb_pkg::MODE_START;
        i_entry_value  <= '0;
        idle_en        <= 1'b1;
        hold_off_asked <= 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store: refused read and advance, start is still legal
        send_request(csb_pkg::MODE_READ, 32'hDEAD_BEEF);
        send_request(csb_pkg::MODE_ADVANCE, '0);
        send_request(csb_pkg::MODE_START, '1);
        // first word is appended, the next goes ahead of it
        send_request(csb_pkg::MODE_INSERT, '0);
        send_request(csb_pkg::MODE_INSERT, '1);
        send_request(csb_pkg::MODE_READ, '0);
        send_request(csb_pkg::MODE_ADVANCE, '0);
        send_request(csb_pkg::MODE_READ, '0);
        // step past the last item, then nothing is current
        send_request(csb_pkg::MODE_ADVANCE, '0);
        send_request(csb_pkg::MODE_READ, '1);
        send_request(csb_pkg::MODE_ADVANCE, '1);
        // no current item: insert appends at the end
        send_request(csb_pkg::MODE_INSERT, 32'h5555_AAAA);
        send_request(csb_pkg::MODE_START, '0);
        send_request(csb_pkg::MODE_ADVANCE, '0);
        // insert in the middle shifts the tail up
        send_request(csb_pkg::MODE_INSERT, 32'h8000_0001);
        send_request(csb_pkg::MODE_START, '0);
        for (item = 0; item < 5; item++) begin
            send_request(csb_pkg::MODE_ADVANCE, '0);
        end

        // random traffic; full store makes later inserts refused
        for (item = 0; item < RANDOM_ITEMS; item++) begin
            if (item == 600) begin
                idle_en <= 1'b0;
            end
            if (item == 700) begin
                hold_off_asked <= hold_off_asked + 1;
            end
            if (item == 900) begin
                idle_en <= 1'b1;
            end
            if (item == RANDOM_ITEMS - TAIL_ITEMS) begin
                idle_en <= 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                op = csb_pkg::MODE_START;
            end else if (pick < 55) begin
                op = csb_pkg::MODE_ADVANCE;
            end else if (pick < 70) begin
                op = csb_pkg::MODE_INSERT;
            end else begin
                op = csb_pkg::MODE_READ;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                word = '0;
            end else if (pick == 1) begin
                word = '1;
            end else begin
                word = $urandom();
            end
            send_request(op, word);
        end
        i_valid <= 1'b0;

        // let every result come out, then watch for strays
        while (pending_results != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
